// ===== src/poly_eval_with_derivative_defines.svh =====
// ----------------------------------------------------------------------------
// poly_eval_with_derivative_defines.svh
// assertion macros of the polynomial evaluator checker
// ----------------------------------------------------------------------------
`ifndef POLY_EVAL_WITH_DERIVATIVE_DEFINES_SVH
`define POLY_EVAL_WITH_DERIVATIVE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PEWD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PEWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pewd_pkg.sv =====
// ----------------------------------------------------------------------------
// pewd_pkg
// types, constants and arithmetic helpers of the polynomial evaluator
// ----------------------------------------------------------------------------
package pewd_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // field widths
   localparam int DEG_W   = 4;
   localparam int INDEX_W = 4;
   localparam int COEF_W  = 16;
   localparam int X_W     = 16;
   localparam int ACC_W   = 32;
   localparam int PROD_W  = ACC_W + X_W;
   localparam int RND_W   = PROD_W - 8;
   localparam int SUM_W   = RND_W + 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;

   // clip bounds of the accumulator, at sum width
   localparam logic signed [SUM_W-1:0] ACC_MAX =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

   // controller to datapath commands
   typedef struct packed {
      logic start;
      logic coef_we;
      logic mul_en;
      logic add_en;
      logic d_en;
      logic out_load;
   } cmd_type;

   // clipped accumulator value and clip flag
   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic                    clip;
   } sat_type;

   // round product to 8 fraction bits, add term, clip to 32 bits
   function automatic sat_type horner_add(input logic signed [PROD_W-1:0] prod,
                                          input logic signed [SUM_W-1:0]  addend);
      logic signed [PROD_W-1:0] biased;
      logic signed [RND_W-1:0]  rnd;
      logic signed [SUM_W-1:0]  sum;
      sat_type                  res;
      biased = prod + PROD_W'(128);
      rnd    = biased[PROD_W-1:8];
      sum    = {rnd[RND_W-1], rnd} + addend;
      if (sum > ACC_MAX) begin
         res.value = ACC_MAX[ACC_W-1:0];
         res.clip  = 1'b1;
      end else if (sum < ACC_MIN) begin
         res.value = ACC_MIN[ACC_W-1:0];
         res.clip  = 1'b1;
      end else begin
         res.value = sum[ACC_W-1:0];
         res.clip  = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== src/poly_eval_with_derivative.sv =====
// ----------------------------------------------------------------------------
// poly_eval_with_derivative: horner evaluator of p(x) and p'(x), Q8.8 in, Q24.8 out
// a load beat is accepted only while idle; an evaluate runs a multiply and an add state per
// horner step, then a finish state that waits while the previous result beat is stalled;
// the input is ready again in the cycle that the result beat appears
// reset clears control and degree, coefficients stay undefined until loaded
// ----------------------------------------------------------------------------
module poly_eval_with_derivative #(
   parameter int MAX_TERMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // coef_index[3:0], coef_value[19:4], x_point[35:20], zero
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // poly_result[31:0], deriv_result[63:32]
   output logic        rsp_tuser,   // saturated
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // poly_degree
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   pewd_pkg::cmd_type                     cmd;
   logic [IDX_W-1:0]                      term_idx;
   logic signed [pewd_pkg::ACC_W-1:0]     poly_result;
   logic signed [pewd_pkg::ACC_W-1:0]     deriv_result;

   // sequencer
   pewd_ctrl #(
      .MAX_TERMS (MAX_TERMS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .term_idx    (term_idx)
   );

   // arithmetic and storage
   pewd_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .IDX_W     (IDX_W)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .term_idx     (term_idx),
      .coef_index   (req_tdata[3:0]),
      .coef_value   (req_tdata[19:4]),
      .x_point      (req_tdata[35:20]),
      .poly_result  (poly_result),
      .deriv_result (deriv_result),
      .saturated    (rsp_tuser)
   );

   assign rsp_tdata = {deriv_result, poly_result};

endmodule

// ===== src/pewd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pewd_ctrl
// sequencer: accepts beats, steps the term index, owns the result handshake
// ----------------------------------------------------------------------------
module pewd_ctrl #(
   parameter int MAX_TERMS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [pewd_pkg::DEG_W-1:0]    csr_wr_data,
   output pewd_pkg::cmd_type             cmd,
   output logic [IDX_W-1:0]              term_idx
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              deg_ff, deg_in;
   logic [pewd_pkg::DEG_W-1:0]    degree_ff, degree_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]              deg_eff;
   logic                          accept;
   logic                          out_free;

   // degree clamped to the store depth
   always_comb begin
      if (32'(degree_ff) > MAX_TERMS - 1) begin
         deg_eff = IDX_W'(MAX_TERMS - 1);
      end else begin
         deg_eff = IDX_W'(degree_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign term_idx   = idx_ff;

   // commands to the datapath
   always_comb begin
      cmd.start    = accept && (req_tuser == pewd_pkg::REQ_EVAL);
      cmd.coef_we  = accept && (req_tuser == pewd_pkg::REQ_LOAD);
      cmd.mul_en   = (state_ff == S_MUL);
      cmd.add_en   = (state_ff == S_ADD);
      cmd.d_en     = (idx_ff != deg_ff);
      cmd.out_load = (state_ff == S_FINISH) && out_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      deg_in       = deg_ff;
      degree_in    = csr_wr_en ? csr_wr_data : degree_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == pewd_pkg::REQ_EVAL)) begin
               idx_in   = deg_eff;
               deg_in   = deg_eff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (idx_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_MUL;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         deg_ff       <= '0;
         degree_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         deg_ff       <= deg_in;
         degree_ff    <= degree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/pewd_datapath.sv =====
// ----------------------------------------------------------------------------
// pewd_datapath
// coefficient memory, two horner accumulators and the result register
// ----------------------------------------------------------------------------
module pewd_datapath #(
   parameter int MAX_TERMS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                                   clock,
   input  pewd_pkg::cmd_type                      cmd,
   input  logic [IDX_W-1:0]                       term_idx,
   input  logic [pewd_pkg::INDEX_W-1:0]           coef_index,
   input  logic signed [pewd_pkg::COEF_W-1:0]     coef_value,
   input  logic signed [pewd_pkg::X_W-1:0]        x_point,
   output logic signed [pewd_pkg::ACC_W-1:0]      poly_result,
   output logic signed [pewd_pkg::ACC_W-1:0]      deriv_result,
   output logic                                   saturated
);

   localparam int DC_W = pewd_pkg::COEF_W + IDX_W + 2;

   logic signed [pewd_pkg::COEF_W-1:0] coef_mem [MAX_TERMS];
   logic signed [pewd_pkg::COEF_W-1:0] rd_data_ff;
   logic signed [pewd_pkg::COEF_W-1:0] prev_c_ff;
   logic signed [pewd_pkg::X_W-1:0]    x_ff;
   logic signed [pewd_pkg::ACC_W-1:0]  p_ff;
   logic signed [pewd_pkg::ACC_W-1:0]  d_ff;
   logic signed [pewd_pkg::PROD_W-1:0] prod_p_ff, prod_p_in;
   logic signed [pewd_pkg::PROD_W-1:0] prod_d_ff, prod_d_in;
   logic signed [DC_W-1:0]             dcoef_ff, dcoef_in;
   logic                               sat_ff;
   logic signed [pewd_pkg::ACC_W-1:0]  poly_out_ff;
   logic signed [pewd_pkg::ACC_W-1:0]  deriv_out_ff;
   logic                               sat_out_ff;
   logic signed [IDX_W+1:0]            factor;
   logic signed [pewd_pkg::SUM_W-1:0]  add_p;
   logic signed [pewd_pkg::SUM_W-1:0]  add_d;
   logic                               wr_ok;
   logic [IDX_W-1:0]                   wr_addr;
   pewd_pkg::sat_type                  res_p;
   pewd_pkg::sat_type                  res_d;

   // loads beyond the store are dropped
   assign wr_ok   = 32'(coef_index) < MAX_TERMS;
   assign wr_addr = IDX_W'(coef_index);

   // coefficient memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.coef_we && wr_ok) begin
         coef_mem[wr_addr] <= coef_value;
      end
      rd_data_ff <= coef_mem[term_idx];
   end

   // multiply phase: both accumulators by x, derivative term (i+1)*c[i+1]
   assign factor    = $signed({2'b00, IDX_W'(term_idx) + {{(IDX_W-1){1'b0}}, 1'b1}});
   assign prod_p_in = p_ff * x_ff;
   assign prod_d_in = d_ff * x_ff;
   assign dcoef_in  = prev_c_ff * factor;

   // add phase: round, add the term, clip
   assign add_p = {{(pewd_pkg::SUM_W-pewd_pkg::COEF_W){rd_data_ff[pewd_pkg::COEF_W-1]}},
                   rd_data_ff};
   assign add_d = {{(pewd_pkg::SUM_W-DC_W){dcoef_ff[DC_W-1]}}, dcoef_ff};
   assign res_p = pewd_pkg::horner_add(prod_p_ff, add_p);
   assign res_d = pewd_pkg::horner_add(prod_d_ff, add_d);

   // accumulator registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff   <= x_point;
         p_ff   <= '0;
         d_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.add_en) begin
         p_ff      <= res_p.value;
         prev_c_ff <= rd_data_ff;
         if (cmd.d_en) begin
            d_ff <= res_d.value;
         end
         sat_ff <= sat_ff | res_p.clip | (cmd.d_en & res_d.clip);
      end
      if (cmd.mul_en) begin
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
         dcoef_ff  <= dcoef_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         poly_out_ff  <= p_ff;
         deriv_out_ff <= d_ff;
         sat_out_ff   <= sat_ff;
      end
   end

   assign poly_result  = poly_out_ff;
   assign deriv_result = deriv_out_ff;
   assign saturated    = sat_out_ff;

endmodule

// ===== src/pewd_checker.sv =====
// ----------------------------------------------------------------------------
// pewd_checker
// port-level checks of the polynomial evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "poly_eval_with_derivative_defines.svh"

module pewd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic load_beat;
   logic eval_beat;

   assign load_beat = req_tvalid && req_tready && (req_tuser == pewd_pkg::REQ_LOAD);
   assign eval_beat = req_tvalid && req_tready && (req_tuser == pewd_pkg::REQ_EVAL);

   // a stalled result beat holds
   `PEWD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   // a load never produces a result
   `PEWD_ASSERT_NEXT(a_load_silent, clock, reset, load_beat && !rsp_tvalid, !rsp_tvalid, "load beat produced a result")

   // an evaluate keeps the input side busy
   `PEWD_ASSERT_NEXT(a_eval_busy, clock, reset, eval_beat, !req_tready, "input ready right after an evaluate beat")

   // a new result appears only at the end of an evaluation
   `PEWD_ASSERT_NOW(a_rsp_after_eval, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared while idle")

endmodule

bind poly_eval_with_derivative pewd_checker u_pewd_checker (.*);
